// File: rtl/core/lbfg_pkg.sv
// ----------------------------------------------------------------------------
// lbfg_pkg
// Shared widths, register indexes, reset values and constants for the
// load based frequency governor.
// ----------------------------------------------------------------------------
package lbfg_pkg;

    // field widths
    localparam int LOAD_W = 7;
    localparam int FREQ_W = 22;
    localparam int SDF_W  = 17;
    localparam int CFG_W  = 22;
    localparam int IDX_W  = 3;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_UP_THRESHOLD      = 3'd0;
    localparam logic [IDX_W-1:0] REG_DOWN_DIFFERENTIAL = 3'd1;
    localparam logic [IDX_W-1:0] REG_DYN_THRESHOLD_EN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_FORCE_FULL_MODE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_IO_BUSY_BOOST     = 3'd4;
    localparam logic [IDX_W-1:0] REG_SAMPLING_DOWN     = 3'd5;
    localparam logic [IDX_W-1:0] REG_HW_MIN_FREQ       = 3'd6;
    localparam logic [IDX_W-1:0] REG_HW_MAX_FREQ       = 3'd7;

    // register reset values
    localparam logic [LOAD_W-1:0] UP_THRESHOLD_RST      = 7'd95;
    localparam logic [LOAD_W-1:0] DOWN_DIFFERENTIAL_RST = 7'd15;
    localparam logic [SDF_W-1:0]  SAMPLING_DOWN_RST     = 17'd5;
    localparam logic [FREQ_W-1:0] HW_MIN_FREQ_RST       = 22'd0;
    localparam logic [FREQ_W-1:0] HW_MAX_FREQ_RST       = 22'h3FFFFF;

    // load arithmetic constants
    localparam logic [LOAD_W-1:0] LOAD_FULL      = 7'd100;
    localparam logic [LOAD_W-1:0] LOAD_BOOST_MIN = 7'd50;
    localparam logic [LOAD_W:0]   LOAD_JUMP      = 8'd35;
    localparam logic [LOAD_W-1:0] LOAD_DEADBAND  = 7'd3;
    localparam logic [LOAD_W-1:0] THR_RAISE      = 7'd5;
    localparam logic [LOAD_W-1:0] THR_MIN        = 7'd1;
    localparam logic [SDF_W-1:0]  SDF_MIN        = 17'd1;
    localparam logic [SDF_W-1:0]  SDF_MAX        = 17'd100000;

    // divide by 100 as multiply by ceil(2^36 / 100), exact for products below 2^29
    localparam int              PROD_W       = LOAD_W + FREQ_W;
    localparam int              DIV100_SHIFT = 36;
    localparam int              DIV100_W     = 30;
    localparam logic [DIV100_W-1:0] DIV100_MULT = 30'd687194768;
    localparam int              QPROD_W      = PROD_W + DIV100_W;

endpackage

// File: rtl/core/load_based_frequency_governor.sv
// ----------------------------------------------------------------------------
// load_based_frequency_governor
// Ondemand style governor: smooths the sampled load and issues a frequency
// request with a sampling rate multiplier for every sample.
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle while the result channel does not stall, and each gives
// exactly one result word after passing the input register, smoothing and decision with
// load times span product, divide by 100, and the final add into the output register.
// Throughput is one sample per cycle without stalls; it is set by the smoothing loop,
// which reads and writes the previous load in the same cycle. The divide by 100 is a
// reciprocal multiply in its own stage. Configuration writes take effect at once and
// are meant to happen only while the pipeline is empty; writing the sampling down
// factor also resets the rate multiplier to one.
module load_based_frequency_governor (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [lbfg_pkg::IDX_W-1:0]         cfg_index,
    input  logic [lbfg_pkg::CFG_W-1:0]         cfg_data,
    // sample channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lbfg_pkg::LOAD_W-1:0]        load_pct,
    input  logic [lbfg_pkg::FREQ_W-1:0]        cur_freq,
    input  logic [lbfg_pkg::FREQ_W-1:0]        limit_max_freq,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               request_valid,
    output logic [lbfg_pkg::FREQ_W-1:0]        target_freq,
    output logic                               relation,
    output logic [lbfg_pkg::SDF_W-1:0]         rate_multiplier
);

    typedef struct packed {
        logic                              req;
        logic                              rel;
        logic                              interp;
        logic [lbfg_pkg::FREQ_W-1:0]       freq;
        logic [lbfg_pkg::PROD_W-1:0]       prod;
        logic [lbfg_pkg::SDF_W-1:0]        rate;
    } s1_word_t;

    typedef struct packed {
        logic                              req;
        logic                              rel;
        logic                              interp;
        logic [lbfg_pkg::FREQ_W-1:0]       freq;
        logic [lbfg_pkg::SDF_W-1:0]        rate;
    } s2_word_t;

    // configuration registers
    logic [lbfg_pkg::LOAD_W-1:0]  up_threshold_reg;
    logic [lbfg_pkg::LOAD_W-1:0]  down_differential_reg;
    logic                         dyn_threshold_en_reg;
    logic                         force_full_mode_reg;
    logic                         io_busy_boost_reg;
    logic [lbfg_pkg::SDF_W-1:0]   sampling_down_reg;
    logic [lbfg_pkg::FREQ_W-1:0]  hw_min_freq_reg;
    logic [lbfg_pkg::FREQ_W-1:0]  hw_max_freq_reg;

    // governor state
    logic [lbfg_pkg::LOAD_W-1:0]  last_load_reg, last_load_next;
    logic [lbfg_pkg::SDF_W-1:0]   rate_mult_reg, rate_mult_next;

    // pipeline registers
    logic                         s0_valid_reg;
    logic [lbfg_pkg::LOAD_W-1:0]  s0_load_reg;
    logic [lbfg_pkg::FREQ_W-1:0]  s0_cur_reg;
    logic [lbfg_pkg::FREQ_W-1:0]  s0_lmax_reg;
    logic                         s1_valid_reg;
    s1_word_t                     s1_reg, s1_next;
    logic                         s2_valid_reg;
    s2_word_t                     s2_reg, s2_next;
    logic                         out_valid_reg;
    logic                         request_valid_reg;
    logic [lbfg_pkg::FREQ_W-1:0]  target_freq_reg, target_freq_next;
    logic                         relation_reg;
    logic [lbfg_pkg::SDF_W-1:0]   rate_multiplier_reg;

    // stage enables
    logic en_out, en2, en1, en0;

    // stage 1 datapath
    logic [lbfg_pkg::LOAD_W-1:0]  load_sat, load_half, load_boost, load_avg, load_sel;
    logic [lbfg_pkg::LOAD_W-1:0]  load_diff, load_keep, load_fin;
    logic [lbfg_pkg::LOAD_W+1:0]  avg_sum;
    logic [lbfg_pkg::LOAD_W-1:0]  thr_base, thr, dd;
    logic [lbfg_pkg::SDF_W-1:0]   sdf;
    logic [lbfg_pkg::FREQ_W-1:0]  span;
    logic                         high_freq, jump, above, below;

    // stage 2 datapath
    logic [lbfg_pkg::QPROD_W-1:0] qprod;

    // stall chain, each stage loads when the next one is empty or moving
    assign en_out   = !out_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en_out;
    assign en1      = !s1_valid_reg || en2;
    assign en0      = !s0_valid_reg || en1;
    assign in_ready = en0;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_threshold_reg      <= lbfg_pkg::UP_THRESHOLD_RST;
            down_differential_reg <= lbfg_pkg::DOWN_DIFFERENTIAL_RST;
            dyn_threshold_en_reg  <= 1'b0;
            force_full_mode_reg   <= 1'b0;
            io_busy_boost_reg     <= 1'b1;
            sampling_down_reg     <= lbfg_pkg::SAMPLING_DOWN_RST;
            hw_min_freq_reg       <= lbfg_pkg::HW_MIN_FREQ_RST;
            hw_max_freq_reg       <= lbfg_pkg::HW_MAX_FREQ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lbfg_pkg::REG_UP_THRESHOLD:
                    up_threshold_reg <= cfg_data[lbfg_pkg::LOAD_W-1:0];
                lbfg_pkg::REG_DOWN_DIFFERENTIAL:
                    down_differential_reg <= cfg_data[lbfg_pkg::LOAD_W-1:0];
                lbfg_pkg::REG_DYN_THRESHOLD_EN:
                    dyn_threshold_en_reg <= cfg_data[0];
                lbfg_pkg::REG_FORCE_FULL_MODE:
                    force_full_mode_reg <= cfg_data[0];
                lbfg_pkg::REG_IO_BUSY_BOOST:
                    io_busy_boost_reg <= cfg_data[0];
                lbfg_pkg::REG_SAMPLING_DOWN:
                    sampling_down_reg <= cfg_data[lbfg_pkg::SDF_W-1:0];
                lbfg_pkg::REG_HW_MIN_FREQ:
                    hw_min_freq_reg <= cfg_data;
                lbfg_pkg::REG_HW_MAX_FREQ:
                    hw_max_freq_reg <= cfg_data;
                default:
                    up_threshold_reg <= up_threshold_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en0)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && en0)
        begin
            s0_load_reg <= load_pct;
            s0_cur_reg  <= cur_freq;
            s0_lmax_reg <= limit_max_freq;
        end
    end

    // saturate registers and input load
    always_comb
    begin
        load_sat = (s0_load_reg > lbfg_pkg::LOAD_FULL) ? lbfg_pkg::LOAD_FULL : s0_load_reg;
        if (up_threshold_reg < lbfg_pkg::THR_MIN)
            thr_base = lbfg_pkg::THR_MIN;
        else if (up_threshold_reg > lbfg_pkg::LOAD_FULL)
            thr_base = lbfg_pkg::LOAD_FULL;
        else
            thr_base = up_threshold_reg;
        dd = (down_differential_reg > lbfg_pkg::LOAD_FULL) ? lbfg_pkg::LOAD_FULL
                                                           : down_differential_reg;
        if (sampling_down_reg < lbfg_pkg::SDF_MIN)
            sdf = lbfg_pkg::SDF_MIN;
        else if (sampling_down_reg > lbfg_pkg::SDF_MAX)
            sdf = lbfg_pkg::SDF_MAX;
        else
            sdf = sampling_down_reg;
    end

    // io boost, smoothing, deadband and threshold
    always_comb
    begin
        high_freq = s0_cur_reg > (s0_lmax_reg >> 1);
        thr = thr_base;
        if (dyn_threshold_en_reg && !force_full_mode_reg && high_freq)
            thr = thr_base + lbfg_pkg::THR_RAISE;

        load_half  = (lbfg_pkg::LOAD_FULL - load_sat) >> 1;
        load_boost = load_sat;
        if (io_busy_boost_reg)
        begin
            if (load_sat > lbfg_pkg::LOAD_BOOST_MIN && high_freq)
                load_boost = lbfg_pkg::LOAD_FULL;
            else
                load_boost = load_sat + load_half;
        end

        jump     = {1'b0, load_boost} > ({1'b0, last_load_reg} + lbfg_pkg::LOAD_JUMP);
        avg_sum  = ({2'b00, load_boost} << 1) + {2'b00, load_boost} + {2'b00, last_load_reg};
        load_avg = avg_sum[lbfg_pkg::LOAD_W+1:2];
        load_sel = jump ? load_boost : load_avg;

        load_diff = (load_sel > last_load_reg) ? (load_sel - last_load_reg)
                                               : (last_load_reg - load_sel);
        load_keep = (load_diff < lbfg_pkg::LOAD_DEADBAND) ? last_load_reg : load_sel;
        load_fin  = force_full_mode_reg ? lbfg_pkg::LOAD_FULL : load_keep;

        above = load_fin > thr;
        below = ({1'b0, load_fin} + {1'b0, dd}) <= {1'b0, thr};
        span  = (hw_max_freq_reg >= hw_min_freq_reg) ? (hw_max_freq_reg - hw_min_freq_reg)
                                                     : '0;
    end

    // decision and load times span product
    always_comb
    begin
        s1_next.req    = 1'b0;
        s1_next.rel    = 1'b0;
        s1_next.interp = 1'b0;
        s1_next.freq   = '0;
        s1_next.prod   = lbfg_pkg::PROD_W'(load_fin) * lbfg_pkg::PROD_W'(span);
        rate_mult_next = rate_mult_reg;
        if (above)
        begin
            if (s0_cur_reg < s0_lmax_reg)
                rate_mult_next = sdf;
            if (s0_cur_reg != s0_lmax_reg)
            begin
                s1_next.req  = 1'b1;
                s1_next.freq = s0_lmax_reg;
            end
        end
        else if (below)
        begin
            s1_next.req    = 1'b1;
            s1_next.rel    = 1'b1;
            s1_next.interp = 1'b1;
            rate_mult_next = lbfg_pkg::SDF_MIN;
        end
        s1_next.rate   = rate_mult_next;
        last_load_next = load_keep;
    end

    // governor state, a down factor write restarts the multiplier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_load_reg <= '0;
            rate_mult_reg <= lbfg_pkg::SDF_MIN;
        end
        else if (cfg_we && cfg_index == lbfg_pkg::REG_SAMPLING_DOWN)
        begin
            rate_mult_reg <= lbfg_pkg::SDF_MIN;
        end
        else if (s0_valid_reg && en1)
        begin
            last_load_reg <= last_load_next;
            rate_mult_reg <= rate_mult_next;
        end
    end

    // stage 1 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= s0_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s0_valid_reg && en1)
            s1_reg <= s1_next;
    end

    // divide by 100 through the reciprocal
    always_comb
    begin
        qprod = lbfg_pkg::QPROD_W'(s1_reg.prod) * lbfg_pkg::QPROD_W'(lbfg_pkg::DIV100_MULT);
        s2_next.req    = s1_reg.req;
        s2_next.rel    = s1_reg.rel;
        s2_next.interp = s1_reg.interp;
        s2_next.rate   = s1_reg.rate;
        s2_next.freq   = s1_reg.interp
                       ? qprod[lbfg_pkg::DIV100_SHIFT+lbfg_pkg::FREQ_W-1:lbfg_pkg::DIV100_SHIFT]
                       : s1_reg.freq;
    end

    // stage 2 register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && en2)
            s2_reg <= s2_next;
    end

    // interpolated target is offset by the hardware minimum
    assign target_freq_next = s2_reg.interp ? (hw_min_freq_reg + s2_reg.freq) : s2_reg.freq;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && en_out)
        begin
            request_valid_reg   <= s2_reg.req;
            target_freq_reg     <= target_freq_next;
            relation_reg        <= s2_reg.rel;
            rate_multiplier_reg <= s2_reg.rate;
        end
    end

    assign out_valid       = out_valid_reg;
    assign request_valid   = request_valid_reg;
    assign target_freq     = target_freq_reg;
    assign relation        = relation_reg;
    assign rate_multiplier = rate_multiplier_reg;

`ifndef SYNTH
    // smoothed load never leaves the percent range
    assert property (@(posedge clk) disable iff (!rst_n)
        last_load_reg <= lbfg_pkg::LOAD_FULL)
        else $error("smoothed load out of range");

    // multiplier stays within the saturated factor range
    assert property (@(posedge clk) disable iff (!rst_n)
        rate_mult_reg >= lbfg_pkg::SDF_MIN && rate_mult_reg <= lbfg_pkg::SDF_MAX)
        else $error("rate multiplier out of range");

    // a down factor write restarts the multiplier
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == lbfg_pkg::REG_SAMPLING_DOWN |=> rate_mult_reg == lbfg_pkg::SDF_MIN)
        else $error("rate multiplier not restarted");

    // interpolated requests always come with a multiplier of one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && relation |-> request_valid && rate_multiplier == lbfg_pkg::SDF_MIN)
        else $error("interpolated request with raised multiplier");

    // a word without request carries no target
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !request_valid |-> target_freq == '0 && !relation)
        else $error("target on a word without request");
`endif

endmodule

// File: tb/sv/load_based_frequency_governor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// load_based_frequency_governor_tb
// Self-checking bench for the load based frequency governor: a directed table
// of samples and register writes, then random phases of settings and sampled
// load traces, with bursty input, a stalling result sink and an in-bench governor
// model that predicts every result word not given in the table.
// ----------------------------------------------------------------------------
module load_based_frequency_governor_tb;

    localparam int             IDLE_LIMIT   = 5000;
    localparam int             SETTLE_CYC   = 8;
    localparam int             LONG_HOLD    = 400;
    localparam int             NUM_PHASES   = 10;
    localparam int             PHASE_ITEMS  = 200;
    localparam logic [lbfg_pkg::FREQ_W-1:0] FREQ_TOP = '1;

    typedef struct packed {
        logic [lbfg_pkg::LOAD_W-1:0] load;
        logic [lbfg_pkg::FREQ_W-1:0] cur;
        logic [lbfg_pkg::FREQ_W-1:0] lmax;
    } sample_t;

    typedef struct packed {
        logic                        req;
        logic [lbfg_pkg::FREQ_W-1:0] target;
        logic                        rel;
        logic [lbfg_pkg::SDF_W-1:0]  mult;
    } request_t;

    typedef struct {
        bit                          is_reg;
        logic [lbfg_pkg::IDX_W-1:0]  idx;
        logic [lbfg_pkg::CFG_W-1:0]  val;
        sample_t                     smp;
        bit                          typed;
        request_t                    want;
    } plan_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [lbfg_pkg::IDX_W-1:0]   cfg_index;
    logic [lbfg_pkg::CFG_W-1:0]   cfg_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [lbfg_pkg::LOAD_W-1:0]  load_pct;
    logic [lbfg_pkg::FREQ_W-1:0]  cur_freq;
    logic [lbfg_pkg::FREQ_W-1:0]  limit_max_freq;
    logic                         out_valid;
    logic                         out_ready;
    logic                         request_valid;
    logic [lbfg_pkg::FREQ_W-1:0]  target_freq;
    logic                         relation;
    logic [lbfg_pkg::SDF_W-1:0]   rate_multiplier;

    // governor model: register copies and state
    logic [lbfg_pkg::LOAD_W-1:0]  cfg_up_thr;
    logic [lbfg_pkg::LOAD_W-1:0]  cfg_down_diff;
    logic                         cfg_dyn_thr;
    logic                         cfg_full;
    logic                         cfg_io_boost;
    logic [lbfg_pkg::SDF_W-1:0]   cfg_down_factor;
    logic [lbfg_pkg::FREQ_W-1:0]  cfg_hw_min;
    logic [lbfg_pkg::FREQ_W-1:0]  cfg_hw_max;
    logic [lbfg_pkg::LOAD_W-1:0]  smooth_load;
    logic [lbfg_pkg::SDF_W-1:0]   period_mult;

    request_t           pending_requests[$];
    plan_row_t          plan[$];
    int                 fail_count;
    int                 sent_count;
    int                 burst_left;
    int                 walk_load;
    int                 idle_cycles;

    load_based_frequency_governor u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .load_pct        (load_pct),
        .cur_freq        (cur_freq),
        .limit_max_freq  (limit_max_freq),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .request_valid   (request_valid),
        .target_freq     (target_freq),
        .relation        (relation),
        .rate_multiplier (rate_multiplier)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // model state after reset
    function automatic void governor_reset();
        cfg_up_thr      = lbfg_pkg::UP_THRESHOLD_RST;
        cfg_down_diff   = lbfg_pkg::DOWN_DIFFERENTIAL_RST;
        cfg_dyn_thr     = 1'b0;
        cfg_full        = 1'b0;
        cfg_io_boost    = 1'b1;
        cfg_down_factor = lbfg_pkg::SAMPLING_DOWN_RST;
        cfg_hw_min      = lbfg_pkg::HW_MIN_FREQ_RST;
        cfg_hw_max      = lbfg_pkg::HW_MAX_FREQ_RST;
        smooth_load     = '0;
        period_mult     = 1;
    endfunction

    // one sample through the governor model, updates smoothed load and multiplier
    function automatic request_t governor_decide(input sample_t s);
        int unsigned       ld;
        int unsigned       thr;
        int unsigned       dd;
        int unsigned       sdf;
        int unsigned       diff;
        int unsigned       span;
        longint unsigned   tgt;
        bit                hi_freq;
        request_t          r;
        ld  = (s.load > 100) ? 100 : s.load;
        thr = (cfg_up_thr < 1) ? 1 : ((cfg_up_thr > 100) ? 100 : cfg_up_thr);
        dd  = (cfg_down_diff > 100) ? 100 : cfg_down_diff;
        sdf = (cfg_down_factor == 0) ? 1 :
              ((cfg_down_factor > 100000) ? 100000 : cfg_down_factor);
        hi_freq = s.cur > (s.lmax / 2);
        r = '0;

        // raised threshold at high frequency
        if (cfg_dyn_thr && !cfg_full && hi_freq)
            thr = thr + 5;

        // io boost toward full load
        if (cfg_io_boost)
        begin
            if (ld > 50 && hi_freq)
                ld = 100;
            else
                ld = ld + (100 - ld) / 2;
        end

        // weighted average unless the load jumps, then deadband
        if (!(ld > smooth_load + 35))
            ld = (ld * 3 + smooth_load) / 4;
        diff = (ld > smooth_load) ? ld - smooth_load : smooth_load - ld;
        if (diff < 3)
            ld = smooth_load;
        smooth_load = lbfg_pkg::LOAD_W'(ld);

        if (cfg_full)
            ld = 100;

        // decision
        if (ld > thr)
        begin
            if (s.cur < s.lmax)
                period_mult = lbfg_pkg::SDF_W'(sdf);
            if (s.cur != s.lmax)
            begin
                r.req    = 1'b1;
                r.target = s.lmax;
                r.rel    = 1'b0;
            end
        end
        else if (ld + dd <= thr)
        begin
            span = (cfg_hw_max >= cfg_hw_min) ? cfg_hw_max - cfg_hw_min : 0;
            tgt  = ld;
            tgt  = cfg_hw_min + (tgt * span) / 100;
            r.target    = tgt[lbfg_pkg::FREQ_W-1:0];
            r.req       = 1'b1;
            r.rel       = 1'b1;
            period_mult = 1;
        end
        r.mult = period_mult;
        return r;
    endfunction

    // register write, the caller lowers cfg_we after the last one
    task automatic reg_write(input logic [lbfg_pkg::IDX_W-1:0] idx,
                             input logic [lbfg_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            lbfg_pkg::REG_UP_THRESHOLD:      cfg_up_thr    = val[lbfg_pkg::LOAD_W-1:0];
            lbfg_pkg::REG_DOWN_DIFFERENTIAL: cfg_down_diff = val[lbfg_pkg::LOAD_W-1:0];
            lbfg_pkg::REG_DYN_THRESHOLD_EN:  cfg_dyn_thr   = val[0];
            lbfg_pkg::REG_FORCE_FULL_MODE:   cfg_full      = val[0];
            lbfg_pkg::REG_IO_BUSY_BOOST:     cfg_io_boost  = val[0];
            lbfg_pkg::REG_SAMPLING_DOWN:
            begin
                cfg_down_factor = val[lbfg_pkg::SDF_W-1:0];
                period_mult     = 1;
            end
            lbfg_pkg::REG_HW_MIN_FREQ:       cfg_hw_min    = val[lbfg_pkg::FREQ_W-1:0];
            lbfg_pkg::REG_HW_MAX_FREQ:       cfg_hw_max    = val[lbfg_pkg::FREQ_W-1:0];
            default: ;
        endcase
    endtask

    // stop offering and wait until every expected word has come back
    task automatic drain_requests();
        in_valid <= 1'b0;
        while (pending_requests.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // offer one sample, record its expected word at acceptance, then maybe gap
    task automatic send_sample(input sample_t s, input bit typed, input request_t want);
        request_t pred;
        in_valid       <= 1'b1;
        load_pct       <= s.load;
        cur_freq       <= s.cur;
        limit_max_freq <= s.lmax;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = governor_decide(s);
        pending_requests.push_back(typed ? want : pred);
        sent_count++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(10, 30)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(100, 300);
            else
                burst_left = $urandom_range(1, 30);
        end
    endtask

    // load trace that mostly wanders near the last value
    function automatic sample_t random_sample();
        sample_t     s;
        int          w;
        int unsigned p;
        int unsigned q;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            w = walk_load + int'($urandom_range(0, 10)) - 5;
            w = (w < 0) ? 0 : ((w > 100) ? 100 : w);
        end
        else if (p < 80)
            w = $urandom_range(0, 100);
        else if (p < 90)
            w = $urandom_range(101, 127);
        else
            w = ($urandom_range(0, 1) != 0) ? 100 : 0;
        walk_load = (w > 100) ? 100 : w;
        s.load = lbfg_pkg::LOAD_W'(w);

        q = $urandom_range(0, 99);
        if (q < 8)
            s.lmax = '0;
        else if (q < 16)
            s.lmax = FREQ_TOP;
        else
            s.lmax = lbfg_pkg::FREQ_W'($urandom_range(0, FREQ_TOP));

        q = $urandom_range(0, 99);
        if (q < 25)
            s.cur = s.lmax;
        else if (q < 45)
            s.cur = (s.lmax / 2) + lbfg_pkg::FREQ_W'($urandom_range(0, 1));
        else if (q < 70)
            s.cur = (s.lmax == 0) ? '0 : lbfg_pkg::FREQ_W'($urandom_range(0, s.lmax - 1));
        else if (q < 85)
            s.cur = (s.lmax == FREQ_TOP) ? s.lmax :
                    lbfg_pkg::FREQ_W'($urandom_range(s.lmax + 1, FREQ_TOP));
        else
            s.cur = lbfg_pkg::FREQ_W'($urandom_range(0, FREQ_TOP));
        return s;
    endfunction

    // new random settings for every register, with the extremes weighted in
    task automatic program_random_settings();
        int unsigned p;
        int unsigned v;
        int unsigned lo;
        int unsigned hi;
        drain_requests();

        p = $urandom_range(0, 9);
        v = (p == 0) ? 0 : (p == 1) ? 127 : (p == 2) ? 100 : (p == 3) ? 1 :
            $urandom_range(40, 100);
        reg_write(lbfg_pkg::REG_UP_THRESHOLD, lbfg_pkg::CFG_W'(v));

        p = $urandom_range(0, 9);
        v = (p == 0) ? 0 : (p == 1) ? 127 : (p == 2) ? 100 : $urandom_range(0, 40);
        reg_write(lbfg_pkg::REG_DOWN_DIFFERENTIAL, lbfg_pkg::CFG_W'(v));

        reg_write(lbfg_pkg::REG_DYN_THRESHOLD_EN, lbfg_pkg::CFG_W'($urandom_range(0, 1)));
        reg_write(lbfg_pkg::REG_FORCE_FULL_MODE, lbfg_pkg::CFG_W'($urandom_range(0, 3) == 0));
        reg_write(lbfg_pkg::REG_IO_BUSY_BOOST, lbfg_pkg::CFG_W'($urandom_range(0, 9) < 7));

        p = $urandom_range(0, 9);
        v = (p == 0) ? 0 : (p == 1) ? 32'h1FFFF : (p == 2) ? 100000 :
            $urandom_range(1, 20);
        reg_write(lbfg_pkg::REG_SAMPLING_DOWN, lbfg_pkg::CFG_W'(v));

        p = $urandom_range(0, 99);
        if (p < 15)
        begin
            // inverted hardware range
            hi = $urandom_range(0, FREQ_TOP - 1);
            lo = $urandom_range(hi + 1, FREQ_TOP);
        end
        else if (p < 20)
        begin
            lo = 0;
            hi = FREQ_TOP;
        end
        else if (p < 25)
        begin
            lo = $urandom_range(0, FREQ_TOP);
            hi = lo;
        end
        else
        begin
            lo = $urandom_range(0, 32'h200000);
            hi = $urandom_range(lo, FREQ_TOP);
        end
        reg_write(lbfg_pkg::REG_HW_MIN_FREQ, lbfg_pkg::CFG_W'(lo));
        reg_write(lbfg_pkg::REG_HW_MAX_FREQ, lbfg_pkg::CFG_W'(hi));
        cfg_we <= 1'b0;
    endtask

    // directed table rows
    function automatic void plan_sample(input logic [lbfg_pkg::LOAD_W-1:0] ld,
                                        input logic [lbfg_pkg::FREQ_W-1:0] cur,
                                        input logic [lbfg_pkg::FREQ_W-1:0] lmax);
        plan_row_t row;
        row        = '{default: '0};
        row.smp    = '{load: ld, cur: cur, lmax: lmax};
        plan.push_back(row);
    endfunction

    function automatic void plan_typed(input logic [lbfg_pkg::LOAD_W-1:0] ld,
                                       input logic [lbfg_pkg::FREQ_W-1:0] cur,
                                       input logic [lbfg_pkg::FREQ_W-1:0] lmax,
                                       input request_t want);
        plan_row_t row;
        row        = '{default: '0};
        row.smp    = '{load: ld, cur: cur, lmax: lmax};
        row.typed  = 1'b1;
        row.want   = want;
        plan.push_back(row);
    endfunction

    function automatic void plan_reg(input logic [lbfg_pkg::IDX_W-1:0] idx,
                                     input logic [lbfg_pkg::CFG_W-1:0] val);
        plan_row_t row;
        row        = '{default: '0};
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        plan.push_back(row);
    endfunction

    // stimulus
    initial
    begin : stimulus
        bit        wr_open;
        sample_t   s;
        governor_reset();
        fail_count     = 0;
        sent_count     = 0;
        burst_left     = 0;
        walk_load      = 0;
        wr_open        = 1'b0;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        load_pct       <= '0;
        cur_freq       <= '0;
        limit_max_freq <= '0;

        // after reset, extremes, limit reached, saturated load
        plan_typed(7'd0, '0, '0, '{req: 1'b1, target: 22'd2097151, rel: 1'b1, mult: 17'd1});
        plan_typed(7'd100, FREQ_TOP, FREQ_TOP, '{req: 1'b0, target: '0, rel: 1'b0, mult: 17'd1});
        plan_typed(7'd100, '0, FREQ_TOP, '{req: 1'b1, target: FREQ_TOP, rel: 1'b0, mult: 17'd5});
        plan_typed(7'd127, 22'd1, 22'd2, '{req: 1'b1, target: 22'd2, rel: 1'b0, mult: 17'd5});
        plan_sample(7'd60, '0, 22'd1000);
        plan_sample(7'd0, FREQ_TOP, '0);
        // no io boost
        plan_reg(lbfg_pkg::REG_IO_BUSY_BOOST, '0);
        plan_sample(7'd0, '0, '0);
        plan_sample(7'd1, 22'd2, 22'd2);
        // threshold below range, no band
        plan_reg(lbfg_pkg::REG_DOWN_DIFFERENTIAL, '0);
        plan_reg(lbfg_pkg::REG_UP_THRESHOLD, '0);
        plan_sample(7'd2, '0, FREQ_TOP);
        plan_sample(7'd50, 22'd100, 22'd100);
        // threshold and band above range
        plan_reg(lbfg_pkg::REG_UP_THRESHOLD, 22'd127);
        plan_reg(lbfg_pkg::REG_DOWN_DIFFERENTIAL, 22'd127);
        plan_sample(7'd100, 22'd10, 22'd20);
        plan_sample(7'd0, 22'd10, 22'd20);
        // raised threshold at high frequency
        plan_reg(lbfg_pkg::REG_UP_THRESHOLD, 22'd95);
        plan_reg(lbfg_pkg::REG_DOWN_DIFFERENTIAL, 22'd15);
        plan_reg(lbfg_pkg::REG_DYN_THRESHOLD_EN, 22'd1);
        plan_sample(7'd100, 22'd3000000, 22'd4000000);
        plan_sample(7'd90, 22'd100, 22'd4000000);
        // forced full load, raise disabled
        plan_reg(lbfg_pkg::REG_FORCE_FULL_MODE, 22'd1);
        plan_sample(7'd0, 22'd3000000, 22'd4000000);
        plan_sample(7'd0, 22'd4000000, 22'd4000000);
        // down factor below and above range
        plan_reg(lbfg_pkg::REG_SAMPLING_DOWN, '0);
        plan_sample(7'd0, '0, 22'd1);
        plan_reg(lbfg_pkg::REG_SAMPLING_DOWN, 22'h1FFFF);
        plan_sample(7'd0, '0, 22'd1);
        // inverted hardware range
        plan_reg(lbfg_pkg::REG_FORCE_FULL_MODE, '0);
        plan_reg(lbfg_pkg::REG_DYN_THRESHOLD_EN, '0);
        plan_reg(lbfg_pkg::REG_IO_BUSY_BOOST, 22'd1);
        plan_reg(lbfg_pkg::REG_SAMPLING_DOWN, 22'd100000);
        plan_reg(lbfg_pkg::REG_HW_MIN_FREQ, 22'd1000);
        plan_reg(lbfg_pkg::REG_HW_MAX_FREQ, 22'd500);
        plan_sample(7'd0, '0, '0);
        plan_sample(7'd40, '0, '0);
        // both limits at the top
        plan_reg(lbfg_pkg::REG_HW_MIN_FREQ, FREQ_TOP);
        plan_reg(lbfg_pkg::REG_HW_MAX_FREQ, FREQ_TOP);
        plan_sample(7'd10, '0, '0);
        plan_reg(lbfg_pkg::REG_HW_MIN_FREQ, '0);
        plan_reg(lbfg_pkg::REG_SAMPLING_DOWN, 22'd5);
        plan_sample(7'd100, '0, FREQ_TOP);
        plan_sample(7'd3, 22'd5, FREQ_TOP);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                if (!wr_open)
                    drain_requests();
                reg_write(plan[i].idx, plan[i].val);
                wr_open = 1'b1;
            end
            else
            begin
                if (wr_open)
                begin
                    cfg_we  <= 1'b0;
                    wr_open = 1'b0;
                end
                send_sample(plan[i].smp, plan[i].typed, plan[i].want);
            end
        end

        // random phases, each with fresh settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            program_random_settings();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // one pause mid phase until every word is back
                if (ph == NUM_PHASES / 2 && n == PHASE_ITEMS / 2)
                    drain_requests();
                s = random_sample();
                send_sample(s, 1'b0, '0);
            end
        end

        drain_requests();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result sink: changing stall patterns plus one long hold-off
    initial
    begin : result_sink
        int mode;
        int mode_left;
        int run_left;
        int hold_left;
        int tick;
        bit run_val;
        bit held;
        mode      = 0;
        mode_left = 0;
        run_left  = 0;
        hold_left = 0;
        tick      = 0;
        run_val   = 1'b0;
        held      = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!held && sent_count >= 700)
            begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 300);
                end
                mode_left--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 99) >= 40);
                    2: out_ready <= (tick % 3 == 0);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_left = $urandom_range(1, 12);
                            run_val  = ~run_val;
                        end
                        run_left--;
                        out_ready <= run_val;
                    end
                endcase
            end
        end
    end

    // compare each accepted word with the oldest expected one
    always @(posedge clk)
    begin : result_check
        request_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_requests.size() == 0)
            begin
                $error("result word with no sample pending");
                fail_count++;
            end
            else
            begin
                want = pending_requests.pop_front();
                if (request_valid !== want.req)
                begin
                    $error("request_valid: expected %0d, actual %0d", want.req, request_valid);
                    fail_count++;
                end
                if (target_freq !== want.target)
                begin
                    $error("target_freq: expected %0d, actual %0d", want.target, target_freq);
                    fail_count++;
                end
                if (relation !== want.rel)
                begin
                    $error("relation: expected %0d, actual %0d", want.rel, relation);
                    fail_count++;
                end
                if (rate_multiplier !== want.mult)
                begin
                    $error("rate_multiplier: expected %0d, actual %0d",
                           want.mult, rate_multiplier);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
